@@ hw/rtl/ura_pkg.sv @@
// Shared constants, command and status types for the ultrasonic ranger.
package ura_pkg;

	localparam int AVG_DEPTH = 3;

	localparam int DIST_W    = 13;
	localparam int TIME_W    = 16;
	localparam int THR_W     = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int CNT_W   = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W   = DIST_W + $clog2(AVG_DEPTH);
	localparam int DSTEP_W = $clog2(SUM_W);

	// Distance is width * 343 / 2000; the division runs as a reciprocal multiply.
	localparam int SOUND_NUM   = 343;
	localparam int SOUND_DEN   = 2000;
	localparam int PROD_W      = TIME_W + 9;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W     = 26;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / SOUND_DEN);
	localparam int QUO_W  = PROD_W + RECIP_W - RECIP_SHIFT;
	localparam int CAND_W = DIST_W + 1;

	localparam int PRES_SCALE = 10;

	localparam logic [DIST_W-1:0] RING_RESET    = 13'd4500;
	localparam logic [TIME_W-1:0] TRIG_RESET    = 16'd1100;
	localparam logic [TIME_W-1:0] WAIT_RESET    = 16'd40000;
	localparam logic [DIST_W-1:0] MIN_RESET     = 13'd100;
	localparam logic [DIST_W-1:0] MAX_RESET     = 13'd4500;
	localparam logic [THR_W-1:0]  THRESH_RESET  = 10'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_PULSE = 3'd0,
		REG_ECHO_WAIT     = 3'd1,
		REG_MIN_DIST      = 3'd2,
		REG_MAX_DIST      = 3'd3,
		REG_THRESHOLD     = 3'd4
	} ura_cfg_reg_t;

	typedef struct packed {
		logic tick;
		logic mul;
		logic recip;
		logic corr;
		logic store;
		logic sum_step;
		logic div_step;
		logic load_out;
	} ura_cmd_t;

	typedef struct packed {
		logic done;
		logic sum_last;
		logic div_last;
	} ura_stat_t;

endpackage

@@ hw/rtl/ultrasonic_ranger_with_average.sv @@
// Ultrasonic ranger with running average: top level joining sequencer and datapath.
// A tick item that ends no measurement goes from acceptance straight to the output state,
// where its result is registered once the output register is free; only then is the next item taken.
// A tick that completes a measurement steps through multiply, reciprocal, correction and store, then
// one sum step per entry (N = entries averaged, 1 to 3) and one bit-serial divide step per quotient bit.
// Reset is asynchronous: configuration returns to defaults, ring entries and the internal average to 4500.
module ultrasonic_ranger_with_average (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ura_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ura_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic                              echo_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              trigger_level,
	output logic                              busy_res,
	output logic                              measure_done,
	output logic                              timed_out,
	output logic [ura_pkg::DIST_W-1:0]        latest_mm,
	output logic [ura_pkg::DIST_W-1:0]        average_mm,
	output logic                              presence
);

	ura_pkg::ura_cmd_t  cmd;
	ura_pkg::ura_stat_t stat;

	ura_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ura_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.echo_level    (echo_level),
		.cmd           (cmd),
		.stat          (stat),
		.trigger_level (trigger_level),
		.busy_res      (busy_res),
		.measure_done  (measure_done),
		.timed_out     (timed_out),
		.latest_mm     (latest_mm),
		.average_mm    (average_mm),
		.presence      (presence)
	);

endmodule

@@ hw/rtl/ura_ctrl.sv @@
// Sequencer for the ranger: accepts one tick item and steps the datapath through it.
module ura_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ura_pkg::ura_cmd_t cmd,
	input  ura_pkg::ura_stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RECIP,
		ST_CORR,
		ST_STORE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_ok;

	assign load_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.tick     = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.recip    = (state_q == ST_RECIP);
		cmd.corr     = (state_q == ST_CORR);
		cmd.store    = (state_q == ST_STORE);
		cmd.sum_step = (state_q == ST_SUM);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_OUT) && load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= stat.done ? ST_MUL : ST_OUT;
					end
				end
				ST_MUL:   state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_CORR;
				ST_CORR:  state_q <= ST_STORE;
				ST_STORE: state_q <= ST_SUM;
				ST_SUM: begin
					if (stat.sum_last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/ura_dp.sv @@
// Datapath for the ranger: phase tracking, distance math, ring, average and result register.
module ura_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ura_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ura_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 command,
	input  logic                                 echo_level,
	input  ura_pkg::ura_cmd_t                    cmd,
	output ura_pkg::ura_stat_t                   stat,
	output logic                                 trigger_level,
	output logic                                 busy_res,
	output logic                                 measure_done,
	output logic                                 timed_out,
	output logic [ura_pkg::DIST_W-1:0]           latest_mm,
	output logic [ura_pkg::DIST_W-1:0]           average_mm,
	output logic                                 presence
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	// Configuration registers.
	logic [ura_pkg::TIME_W-1:0] trig_len_q, wait_len_q;
	logic [ura_pkg::DIST_W-1:0] min_dist_q, max_dist_q;
	logic [ura_pkg::THR_W-1:0]  thresh_q;

	// Measurement state.
	phase_t                     phase_q;
	logic [ura_pkg::TIME_W-1:0] timer_q, pw_q;
	logic                       prev_q, rise_seen_q, fall_seen_q;

	// Flags of the current tick.
	logic trig_q, busy_q, done_q, tout_q, ok_q;

	// Distance pipeline.
	logic [ura_pkg::PROD_W-1:0] prod_q;
	logic [ura_pkg::QUO_W-1:0]  qest_q;
	logic [ura_pkg::CAND_W-1:0] cand_q;

	// Ring and average.
	logic [ura_pkg::DIST_W-1:0]  ring_q [ura_pkg::AVG_DEPTH];
	logic [ura_pkg::SLOT_W-1:0]  slot_q, idx_q;
	logic                        full_q;
	logic [ura_pkg::DIST_W-1:0]  latest_q;
	logic [ura_pkg::CNT_W-1:0]   cnt_q, rem_q;
	logic [ura_pkg::SUM_W-1:0]   acc_q, quo_q;
	logic [ura_pkg::DSTEP_W-1:0] dstep_q;

	// Tick evaluation.
	logic                       start, rise, fall, rs0, fs0, rs1, fs1, active;
	logic                       trig_c, done_c, tout_c;
	logic [ura_pkg::TIME_W-1:0] pw0, pw1, tm0, tm1;
	logic [ura_pkg::TIME_W:0]   tm_inc;
	phase_t                     ph1, ph2;

	always_comb begin
		start  = (phase_q == PH_IDLE) && command;
		rs0    = start ? 1'b0 : rise_seen_q;
		fs0    = start ? 1'b0 : fall_seen_q;
		pw0    = start ? '0 : pw_q;
		tm0    = start ? '0 : timer_q;
		ph1    = start ? PH_TRIG : phase_q;
		active = (ph1 != PH_IDLE);
		rise   = echo_level && !prev_q;
		fall   = !echo_level && prev_q;
		rs1    = rs0;
		fs1    = fs0;
		pw1    = pw0;
		if (active) begin
			if (rise) begin
				rs1 = 1'b1;
				fs1 = 1'b0;
				pw1 = '0;
			end else if (rs0 && !fs0 && (pw0 != '1)) begin
				pw1 = pw0 + 1'b1;
			end
			if (fall) begin
				fs1 = 1'b1;
			end
		end
		tm_inc = {1'b0, tm0} + 1'b1;
		ph2    = ph1;
		tm1    = tm0;
		trig_c = 1'b0;
		done_c = 1'b0;
		tout_c = 1'b0;
		unique case (ph1)
			PH_TRIG: begin
				trig_c = 1'b1;
				if (tm_inc >= {1'b0, trig_len_q}) begin
					ph2 = PH_WAIT;
					tm1 = '0;
				end else begin
					tm1 = tm_inc[ura_pkg::TIME_W-1:0];
				end
			end
			PH_WAIT: begin
				if (fs1) begin
					done_c = 1'b1;
					ph2    = PH_IDLE;
					tm1    = '0;
				end else if (tm_inc >= {1'b0, wait_len_q}) begin
					done_c = 1'b1;
					tout_c = 1'b1;
					ph2    = PH_IDLE;
					tm1    = '0;
				end else begin
					tm1 = tm_inc[ura_pkg::TIME_W-1:0];
				end
			end
			PH_IDLE: ;
			default: ;
		endcase
	end

	// Distance arithmetic.
	logic [ura_pkg::PROD_W+ura_pkg::RECIP_W-1:0] recip_prod;
	logic [ura_pkg::PROD_W-1:0]                  back_prod, rem_est;
	logic [ura_pkg::DIST_W-1:0]                  store_d;
	logic [ura_pkg::SLOT_W-1:0]                  slot_nxt;
	logic                                        full_nxt, wrap;

	always_comb begin
		recip_prod = {{ura_pkg::RECIP_W{1'b0}}, prod_q} *
			{{ura_pkg::PROD_W{1'b0}}, ura_pkg::RECIP_M};
		back_prod  = {{(ura_pkg::PROD_W-ura_pkg::QUO_W){1'b0}}, qest_q} *
			ura_pkg::PROD_W'(ura_pkg::SOUND_DEN);
		rem_est    = prod_q - back_prod;
		if (ok_q && (cand_q >= {1'b0, min_dist_q}) && (cand_q <= {1'b0, max_dist_q})) begin
			store_d = cand_q[ura_pkg::DIST_W-1:0];
		end else begin
			store_d = max_dist_q;
		end
		wrap     = (slot_q == ura_pkg::SLOT_W'(ura_pkg::AVG_DEPTH - 1));
		slot_nxt = wrap ? '0 : slot_q + 1'b1;
		full_nxt = full_q || wrap;
	end

	// Average accumulation and restoring division by the entry count.
	logic [ura_pkg::SUM_W-1:0] sum_nxt;
	logic [ura_pkg::CNT_W:0]   rem_sh;
	logic                      qbit;

	always_comb begin
		sum_nxt = acc_q + ura_pkg::SUM_W'(ring_q[idx_q]);
		rem_sh  = {rem_q, quo_q[ura_pkg::SUM_W-1]};
		qbit    = (rem_sh >= {1'b0, cnt_q});
	end

	assign stat.done     = done_c;
	assign stat.sum_last = ((ura_pkg::CNT_W'(idx_q) + 1'b1) == cnt_q);
	assign stat.div_last = (dstep_q == ura_pkg::DSTEP_W'(ura_pkg::SUM_W - 1));

	logic [ura_pkg::DIST_W:0] thr_scaled;
	assign thr_scaled = {{(ura_pkg::DIST_W+1-ura_pkg::THR_W){1'b0}}, thresh_q} *
		(ura_pkg::DIST_W+1)'(ura_pkg::PRES_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_len_q  <= ura_pkg::TRIG_RESET;
			wait_len_q  <= ura_pkg::WAIT_RESET;
			min_dist_q  <= ura_pkg::MIN_RESET;
			max_dist_q  <= ura_pkg::MAX_RESET;
			thresh_q    <= ura_pkg::THRESH_RESET;
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			pw_q        <= '0;
			prev_q      <= 1'b0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
			trig_q      <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			tout_q      <= 1'b0;
			ok_q        <= 1'b0;
			for (int i = 0; i < ura_pkg::AVG_DEPTH; i++) begin
				ring_q[i] <= ura_pkg::RING_RESET;
			end
			slot_q      <= '0;
			full_q      <= 1'b0;
			latest_q    <= ura_pkg::RING_RESET;
			quo_q       <= ura_pkg::SUM_W'(ura_pkg::RING_RESET);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ura_pkg::REG_TRIGGER_PULSE: trig_len_q <= cfg_data;
					ura_pkg::REG_ECHO_WAIT:     wait_len_q <= cfg_data;
					ura_pkg::REG_MIN_DIST:      min_dist_q <= cfg_data[ura_pkg::DIST_W-1:0];
					ura_pkg::REG_MAX_DIST:      max_dist_q <= cfg_data[ura_pkg::DIST_W-1:0];
					ura_pkg::REG_THRESHOLD:     thresh_q   <= cfg_data[ura_pkg::THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.tick) begin
				phase_q     <= ph2;
				timer_q     <= tm1;
				pw_q        <= pw1;
				prev_q      <= echo_level;
				rise_seen_q <= rs1;
				fall_seen_q <= fs1;
				trig_q      <= trig_c;
				busy_q      <= (ph2 != PH_IDLE);
				done_q      <= done_c;
				tout_q      <= tout_c;
				ok_q        <= done_c && !tout_c && rs1 && (pw1 != '0);
			end
			if (cmd.store) begin
				ring_q[slot_q] <= store_d;
				latest_q       <= store_d;
				slot_q         <= slot_nxt;
				full_q         <= full_nxt;
			end
			if (cmd.sum_step && stat.sum_last) begin
				quo_q <= sum_nxt;
			end else if (cmd.div_step) begin
				quo_q <= {quo_q[ura_pkg::SUM_W-2:0], qbit};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= {{(ura_pkg::PROD_W-ura_pkg::TIME_W){1'b0}}, pw_q} *
				ura_pkg::PROD_W'(ura_pkg::SOUND_NUM);
		end
		if (cmd.recip) begin
			qest_q <= recip_prod[ura_pkg::PROD_W+ura_pkg::RECIP_W-1:ura_pkg::RECIP_SHIFT];
		end
		if (cmd.corr) begin
			// The reciprocal estimate is low by at most one.
			if (rem_est >= ura_pkg::PROD_W'(ura_pkg::SOUND_DEN)) begin
				cand_q <= ura_pkg::CAND_W'(qest_q + 1'b1);
			end else begin
				cand_q <= ura_pkg::CAND_W'(qest_q);
			end
		end
		if (cmd.store) begin
			idx_q <= '0;
			acc_q <= '0;
			if (full_nxt) begin
				cnt_q <= ura_pkg::CNT_W'(ura_pkg::AVG_DEPTH);
			end else if (slot_nxt == '0) begin
				cnt_q <= ura_pkg::CNT_W'(1);
			end else begin
				cnt_q <= ura_pkg::CNT_W'(slot_nxt);
			end
		end
		if (cmd.sum_step) begin
			acc_q   <= sum_nxt;
			idx_q   <= idx_q + 1'b1;
			rem_q   <= '0;
			dstep_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q   <= qbit ? ura_pkg::CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[ura_pkg::CNT_W-1:0];
			dstep_q <= dstep_q + 1'b1;
		end
		if (cmd.load_out) begin
			trigger_level <= trig_q;
			busy_res      <= busy_q;
			measure_done  <= done_q;
			timed_out     <= tout_q;
			latest_mm     <= latest_q;
			average_mm    <= quo_q[ura_pkg::DIST_W-1:0];
			presence      <= ({1'b0, quo_q[ura_pkg::DIST_W-1:0]} < thr_scaled);
		end
	end

	// A finished measurement always leaves the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("measurement finished while still busy");

	a_tout_done: assert property (@(posedge clk) disable iff (!arst_n)
		tout_q |-> done_q)
		else $error("timeout flagged without a finished measurement");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= ura_pkg::SLOT_W'(ura_pkg::AVG_DEPTH - 1))
		else $error("ring write slot out of range");

	a_full_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> (slot_q == '0))
		else $error("ring marked full without wrapping");

endmodule

@@ tb/tb_ultrasonic_ranger_with_average.sv @@
// Self-checking testbench for the ultrasonic ranger with running average.
module tb_ultrasonic_ranger_with_average;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int TICK_TARGET   = 850;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD     = 150;
	localparam int ECHO_CAP      = 65535;

	typedef enum logic [1:0] {RANGER_IDLE, RANGER_TRIGGER, RANGER_WAIT} ranger_phase_t;

	typedef struct packed {
		logic command;
		logic echo;
	} tick_item_t;

	typedef struct packed {
		logic                       trigger;
		logic                       busy;
		logic                       done;
		logic                       timeout;
		logic [ura_pkg::DIST_W-1:0] latest;
		logic [ura_pkg::DIST_W-1:0] average;
		logic                       presence;
	} ranger_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [ura_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ura_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          command = 1'b0;
	logic                          echo_level = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          trigger_level;
	logic                          busy_res;
	logic                          measure_done;
	logic                          timed_out;
	logic [ura_pkg::DIST_W-1:0]    latest_mm;
	logic [ura_pkg::DIST_W-1:0]    average_mm;
	logic                          presence;

	ultrasonic_ranger_with_average uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger_level(trigger_level),
		.busy_res(busy_res),
		.measure_done(measure_done),
		.timed_out(timed_out),
		.latest_mm(latest_mm),
		.average_mm(average_mm),
		.presence(presence)
	);

	// Ranger state as the testbench sees it.
	logic [ura_pkg::TIME_W-1:0] trig_len_cfg;
	logic [ura_pkg::TIME_W-1:0] wait_len_cfg;
	logic [ura_pkg::DIST_W-1:0] min_dist_cfg;
	logic [ura_pkg::DIST_W-1:0] max_dist_cfg;
	logic [ura_pkg::THR_W-1:0]  thresh_cfg;
	ranger_phase_t              phase_now;
	int unsigned                phase_ticks;
	int unsigned                echo_width;
	int unsigned                ring_slot;
	logic                       echo_last;
	logic                       rise_seen;
	logic                       fall_seen;
	logic                       ring_wrapped;
	logic [ura_pkg::DIST_W-1:0] dist_ring [ura_pkg::AVG_DEPTH];

	tick_item_t     pending_ticks [$];
	ranger_result_t expected_readings [$];

	int unsigned items_queued = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	logic        item_taken = 1'b0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	logic        long_hold_done = 1'b0;
	logic [31:0] pattern_cycle = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void reset_ranger();
		trig_len_cfg = ura_pkg::TRIG_RESET;
		wait_len_cfg = ura_pkg::WAIT_RESET;
		min_dist_cfg = ura_pkg::MIN_RESET;
		max_dist_cfg = ura_pkg::MAX_RESET;
		thresh_cfg = ura_pkg::THRESH_RESET;
		phase_now = RANGER_IDLE;
		phase_ticks = 0;
		echo_width = 0;
		ring_slot = 0;
		echo_last = 1'b0;
		rise_seen = 1'b0;
		fall_seen = 1'b0;
		ring_wrapped = 1'b0;
		for (int k = 0; k < ura_pkg::AVG_DEPTH; k++) dist_ring[k] = ura_pkg::RING_RESET;
	endfunction

	// A rising edge restarts the pulse count; the count runs until a falling edge.
	function automatic void follow_echo(logic echo);
		if (echo && !echo_last) begin
			rise_seen = 1'b1;
			fall_seen = 1'b0;
			echo_width = 0;
		end else if (rise_seen && !fall_seen && echo_width < ECHO_CAP) begin
			echo_width++;
		end
		if (!echo && echo_last) fall_seen = 1'b1;
	endfunction

	function automatic void store_distance(logic [ura_pkg::DIST_W-1:0] mm);
		dist_ring[ring_slot] = mm;
		ring_slot = (ring_slot + 1) % ura_pkg::AVG_DEPTH;
		if (ring_slot == 0) ring_wrapped = 1'b1;
	endfunction

	function automatic ranger_result_t predict_tick(tick_item_t it);
		ranger_result_t r;
		int unsigned count;
		int unsigned total;
		int unsigned stored_mm;
		r = '0;
		if (phase_now == RANGER_IDLE && it.command == CMD_START) begin
			rise_seen = 1'b0;
			fall_seen = 1'b0;
			echo_width = 0;
			phase_now = RANGER_TRIGGER;
			phase_ticks = 0;
		end
		if (phase_now == RANGER_TRIGGER) begin
			r.trigger = 1'b1;
			follow_echo(it.echo);
			phase_ticks++;
			if (phase_ticks >= 32'(trig_len_cfg)) begin
				phase_now = RANGER_WAIT;
				phase_ticks = 0;
			end
		end else if (phase_now == RANGER_WAIT) begin
			follow_echo(it.echo);
			if (fall_seen) begin
				stored_mm = 32'(max_dist_cfg);
				if (rise_seen && echo_width > 0) begin
					total = echo_width * ura_pkg::SOUND_NUM / ura_pkg::SOUND_DEN;
					if (total >= 32'(min_dist_cfg) && total <= 32'(max_dist_cfg))
						stored_mm = total;
				end
				store_distance(ura_pkg::DIST_W'(stored_mm));
				r.done = 1'b1;
				phase_now = RANGER_IDLE;
				phase_ticks = 0;
			end else begin
				phase_ticks++;
				if (phase_ticks >= 32'(wait_len_cfg)) begin
					store_distance(max_dist_cfg);
					r.done = 1'b1;
					r.timeout = 1'b1;
					phase_now = RANGER_IDLE;
					phase_ticks = 0;
				end
			end
		end
		echo_last = it.echo;
		// Before the ring fills, only the entries written so far are averaged.
		count = ring_wrapped ? ura_pkg::AVG_DEPTH : (ring_slot > 0 ? ring_slot : 1);
		total = 0;
		for (int k = 0; k < count; k++) total += 32'(dist_ring[k]);
		r.average = ura_pkg::DIST_W'(total / count);
		r.latest = dist_ring[(ring_slot + ura_pkg::AVG_DEPTH - 1) % ura_pkg::AVG_DEPTH];
		r.busy = (phase_now != RANGER_IDLE);
		r.presence = (int'(r.average) < int'(thresh_cfg) * ura_pkg::PRES_SCALE);
		return r;
	endfunction

	task automatic check_field(string field, logic [ura_pkg::DIST_W-1:0] want,
		logic [ura_pkg::DIST_W-1:0] got);
		if (want != got) begin
			errors++;
			if (errors < 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Item acceptance and result checking.
	always @(posedge clk) begin
		tick_item_t     seen;
		ranger_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen.command = command;
				seen.echo = echo_level;
				expected_readings.push_back(predict_tick(seen));
				item_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_readings.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected nothing, got latest %0d",
						$time, latest_mm);
				end else begin
					want = expected_readings.pop_front();
					check_field("trigger_level", ura_pkg::DIST_W'(want.trigger),
						ura_pkg::DIST_W'(trigger_level));
					check_field("busy_res", ura_pkg::DIST_W'(want.busy),
						ura_pkg::DIST_W'(busy_res));
					check_field("measure_done", ura_pkg::DIST_W'(want.done),
						ura_pkg::DIST_W'(measure_done));
					check_field("timed_out", ura_pkg::DIST_W'(want.timeout),
						ura_pkg::DIST_W'(timed_out));
					check_field("latest_mm", want.latest, latest_mm);
					check_field("average_mm", want.average, average_mm);
					check_field("presence", ura_pkg::DIST_W'(want.presence),
						ura_pkg::DIST_W'(presence));
				end
			end
		end
	end

	// Sender: bursts of items with random gaps, payload held until taken.
	always @(negedge clk) begin
		tick_item_t next_item;
		logic       valid_next;
		next_item.command = command;
		next_item.echo = echo_level;
		valid_next = in_valid;
		if (!in_valid || item_taken) begin
			item_taken = 1'b0;
			valid_next = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (arst_n && pending_ticks.size() != 0) begin
				next_item = pending_ticks.pop_front();
				valid_next = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
		in_valid <= valid_next;
		command <= next_item.command;
		echo_level <= next_item.echo;
	end

	// Receiver: a free-running counter selects its stall pattern, plus one long hold-off.
	always @(negedge clk) begin
		logic ready_next;
		pattern_cycle++;
		if (!long_hold_done && results_seen >= 300) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			ready_next = 1'b0;
		end else begin
			case (pattern_cycle[7:6])
				2'd0: ready_next = 1'b1;
				2'd1: ready_next = ($urandom_range(0, 3) != 0);
				2'd2: ready_next = (pattern_cycle[2:0] < 3'd5);
				default: ready_next = 1'($urandom_range(0, 1));
			endcase
		end
		out_ready <= ready_next;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_ultrasonic_ranger_with_average failed");
			$finish;
		end
	end

	task automatic queue_tick(logic cmd, logic echo);
		tick_item_t it;
		it.command = cmd;
		it.echo = echo;
		pending_ticks.push_back(it);
		items_queued++;
	endtask

	// A stretch of ticks at one echo level; noisy stretches carry stray starts.
	task automatic queue_run(logic echo, int unsigned n, logic noisy);
		repeat (n) queue_tick(noisy && $urandom_range(0, 7) == 0, echo);
	endtask

	function automatic int unsigned pick_width();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 14) return $urandom_range(1, 16);
		if (roll < 19) return $urandom_range(17, 120);
		return $urandom_range(121, 600);
	endfunction

	task automatic queue_measurement();
		int unsigned shape;
		int unsigned lead;
		int unsigned trig_run;
		shape = $urandom_range(0, 9);
		lead = $urandom_range(0, 3);
		trig_run = (trig_len_cfg > 16'd8) ? 8 : 32'(trig_len_cfg);
		case (shape)
			0: begin
				// Echo already high at the start, so the fall has no rising edge.
				queue_tick(CMD_TICK, 1'b1);
				queue_tick(CMD_START, 1'b1);
				queue_run(1'b1, pick_width(), 1'b1);
				queue_run(1'b0, 2, 1'b0);
			end
			1: begin
				queue_tick(CMD_START, 1'b0);
				queue_run(1'b1, pick_width(), 1'b1);
				queue_run(1'b0, 2, 1'b0);
			end
			2: begin
				queue_tick(CMD_START, 1'b0);
				queue_run(1'b0, $urandom_range(5, 40), 1'b1);
			end
			3: begin
				queue_tick(CMD_START, 1'b0);
				queue_run(1'b1, 40, 1'b0);
				queue_run(1'b0, 1, 1'b0);
			end
			default: begin
				queue_tick(CMD_START, 1'b0);
				queue_run(1'b0, trig_run + lead, 1'b0);
				queue_run(1'b1, pick_width(), 1'b1);
				queue_run(1'b0, $urandom_range(1, 2), 1'b0);
			end
		endcase
	endtask

	task automatic write_reg(ura_pkg::ura_cfg_reg_t idx, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ura_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ura_pkg::REG_TRIGGER_PULSE: trig_len_cfg = ura_pkg::TIME_W'(value);
			ura_pkg::REG_ECHO_WAIT:     wait_len_cfg = ura_pkg::TIME_W'(value);
			ura_pkg::REG_MIN_DIST:      min_dist_cfg = ura_pkg::DIST_W'(value);
			ura_pkg::REG_MAX_DIST:      max_dist_cfg = ura_pkg::DIST_W'(value);
			ura_pkg::REG_THRESHOLD:     thresh_cfg = ura_pkg::THR_W'(value);
			default: ;
		endcase
	endtask

	task automatic write_all(int unsigned trig, int unsigned wait_len, int unsigned mn,
		int unsigned mx, int unsigned thr);
		write_reg(ura_pkg::REG_TRIGGER_PULSE, trig);
		write_reg(ura_pkg::REG_ECHO_WAIT, wait_len);
		write_reg(ura_pkg::REG_MIN_DIST, mn);
		write_reg(ura_pkg::REG_MAX_DIST, mx);
		write_reg(ura_pkg::REG_THRESHOLD, thr);
	endtask

	// Holds the test until every result is back, then lets the pipeline settle.
	task automatic wait_until_idle();
		while (pending_ticks.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned trig, int unsigned wait_len, int unsigned mn,
		int unsigned mx, int unsigned thr, int unsigned n);
		int unsigned stop_at;
		write_all(trig, wait_len, mn, mx, thr);
		stop_at = items_queued + n;
		while (items_queued < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				queue_tick($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
			else
				queue_measurement();
		end
		// A closing pulse ends any measurement still waiting for its echo.
		queue_tick(CMD_TICK, 1'b1);
		queue_run(1'b0, 2, 1'b0);
		wait_until_idle();
	endtask

	initial begin
		reset_ranger();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Outputs straight after reset, under the default registers.
		queue_tick(CMD_TICK, 1'b0);
		queue_tick(CMD_TICK, 1'b1);
		queue_tick(CMD_TICK, 1'b0);
		wait_until_idle();

		write_all(2, 30, 0, 8191, 819);
		// One-tick pulse: zero distance, accepted with a zero minimum.
		queue_tick(CMD_START, 1'b0);
		queue_tick(CMD_TICK, 1'b0);
		queue_tick(CMD_TICK, 1'b1);
		queue_tick(CMD_TICK, 1'b0);
		// Six-tick pulse with a start request while busy.
		queue_tick(CMD_START, 1'b0);
		queue_tick(CMD_TICK, 1'b0);
		queue_tick(CMD_START, 1'b1);
		queue_run(1'b1, 5, 1'b0);
		queue_tick(CMD_TICK, 1'b0);
		// Echo high before the start: a fall without a rise fails the item.
		queue_tick(CMD_TICK, 1'b1);
		queue_tick(CMD_START, 1'b1);
		queue_tick(CMD_TICK, 1'b1);
		queue_tick(CMD_TICK, 1'b0);
		queue_tick(CMD_TICK, 1'b0);
		wait_until_idle();

		run_phase(1, 65535, 0, 8191, 819, 110);
		run_phase(0, 0, 5, 20, 1, 80);
		run_phase(1, 1, 40, 60, 500, 60);
		run_phase(3, 12, 8191, 0, 0, 90);
		run_phase(65535, 40, 0, 8191, 400, 50);
		run_phase(2, 200, 3, 50, 2, 100);
		while (items_queued < TICK_TARGET) begin
			run_phase($urandom_range(1, 4),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(21, 400),
				$urandom_range(0, 12),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(8, 150),
				($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 819),
				120);
		end

		wait_until_idle();
		if (errors == 0 && expected_readings.size() == 0)
			$display("tb_ultrasonic_ranger_with_average passed");
		else
			$display("tb_ultrasonic_ranger_with_average failed");
		$finish;
	end

endmodule
